### rtl/core/cc20_pkg.sv
// Shared constants and types for the ChaCha keystream generator.
// The generator top level and the quarter-round unit use this package.
// It has no dependencies.
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;

  // "expand 32-byte k" as four little-endian words.
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [63:0] SEED_XOR = 64'h123456789ABCDEF0;
  localparam logic [63:0] SEED_MUL = 64'h9e3779b97f4a7c15;

  // The four words that one quarter round works on.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_words_t;

endpackage

### rtl/core/cc20_qr.sv
// Half of a ChaCha quarter round: two add, xor and rotate pairs.
// The first half rotates by 16 and 12, the second half by 8 and 7.
// Depends on cc20_pkg.
`timescale 1ns / 1ps

module cc20_qr (
  input  logic                 second_half,
  input  cc20_pkg::qr_words_t  words_in,
  output cc20_pkg::qr_words_t  words_out
);
  import cc20_pkg::*;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  logic [31:0] a_sum;
  logic [31:0] d_mix;
  logic [31:0] d_rot;
  logic [31:0] c_sum;
  logic [31:0] b_mix;
  logic [31:0] b_rot;

  always_comb begin
    a_sum = words_in.a + words_in.b;
    d_mix = words_in.d ^ a_sum;
    d_rot = second_half ? rotl(d_mix, 8) : rotl(d_mix, 16);
    c_sum = words_in.c + d_rot;
    b_mix = words_in.b ^ c_sum;
    b_rot = second_half ? rotl(b_mix, 7) : rotl(b_mix, 12);
    words_out.a = a_sum;
    words_out.b = b_rot;
    words_out.c = c_sum;
    words_out.d = d_rot;
  end

endmodule

### rtl/core/chacha20_keystream_prng.sv
// Random generator on the ChaCha block function, one 64-bit draw per transaction.
// A draw served from the buffer is valid in the cycle after acceptance; a draw that needs a block
// waits until the shared half quarter-round unit, which does one half quarter round per cycle,
// has run all rounds of the block; a restart first derives the key words from the seed.
// One block serves eight draws; no new draw is accepted while a block is being computed.
// Synchronous reset: seed 0, key words derived from seed 0, counter 0, buffer empty.
`timescale 1ns / 1ps

module chacha20_keystream_prng #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] random_value,
  output logic        new_block
);
  import cc20_pkg::*;

  localparam int DR_W = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KEY   = 5'b00010,
    S_INIT  = 5'b00100,
    S_ROUND = 5'b01000,
    S_FEED  = 5'b10000
  } state_t;

  state_t           state;
  logic [63:0]      seed_value;
  logic [31:0]      key [8];
  logic [63:0]      ctr;
  logic [4:0]       pos;
  logic [31:0]      x [16];
  logic             half;
  logic [1:0]       col;
  logic             diag;
  logic [DR_W-1:0]  dround;
  logic [1:0]       mcnt;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [31:0]      acc_lo;
  logic [31:0]      acc_hi;
  logic [31:0]      acc_hi_next;
  logic [31:0]      init_w [16];
  logic [31:0]      ks [16];
  logic [31:0]      xq [16];
  logic [31:0]      x_round [16];
  logic [1:0]       rot_amt [4];
  logic [1:0]       rsel;
  logic             accept;
  logic             last_step;
  qr_words_t        qr_in;
  qr_words_t        qr_out;

  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign last_step = half && diag && (col == 2'd3) &&
                     (dround == DR_W'(DOUBLE_ROUNDS - 1));

  // Block input words: constants, key, counter and a zero nonce.
  always_comb begin
    init_w[0] = SIGMA0;
    init_w[1] = SIGMA1;
    init_w[2] = SIGMA2;
    init_w[3] = SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init_w[4 + i] = key[i];
    end
    init_w[12] = ctr[31:0];
    init_w[13] = ctr[63:32];
    init_w[14] = 32'd0;
    init_w[15] = 32'd0;
    for (int i = 0; i < 16; i++) begin
      ks[i] = x[i] + init_w[i];
    end
  end

  // The unit always works on column 0; the rows then rotate so that the next
  // column or diagonal lands there. The last step of each half of a double round
  // rotates the rows unevenly to diagonalize or to restore column order.
  assign qr_in = '{a: x[0], b: x[4], c: x[8], d: x[12]};

  cc20_qr u_qr (
    .second_half (half),
    .words_in    (qr_in),
    .words_out   (qr_out)
  );

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rot_amt[r] = 2'd1;
    end
    if (col == 2'd3 && !diag) begin
      rot_amt[0] = 2'd1;
      rot_amt[1] = 2'd2;
      rot_amt[2] = 2'd3;
      rot_amt[3] = 2'd0;
    end else if (col == 2'd3 && diag) begin
      rot_amt[0] = 2'd1;
      rot_amt[1] = 2'd0;
      rot_amt[2] = 2'd3;
      rot_amt[3] = 2'd2;
    end
  end

  always_comb begin
    rsel = 2'd0;
    for (int i = 0; i < 16; i++) begin
      xq[i] = x[i];
    end
    xq[0]  = qr_out.a;
    xq[4]  = qr_out.b;
    xq[8]  = qr_out.c;
    xq[12] = qr_out.d;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        rsel = 2'(j) + rot_amt[r];
        x_round[4 * r + j] = half ? xq[{2'(r), rsel}] : xq[4 * r + j];
      end
    end
  end

  // Seed times the golden-ratio constant, low 64 bits, from three 32x32 products.
  always_comb begin
    unique case (mcnt)
      2'd0:    begin mul_a = seed_value[31:0];  mul_b = SEED_MUL[31:0];  end
      2'd1:    begin mul_a = seed_value[31:0];  mul_b = SEED_MUL[63:32]; end
      2'd2:    begin mul_a = seed_value[63:32]; mul_b = SEED_MUL[31:0];  end
      default: begin mul_a = seed_value[63:32]; mul_b = SEED_MUL[31:0];  end
    endcase
    acc_hi_next = acc_hi + prod[31:0];
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (state == S_KEY && mcnt == 2'd1) begin
      acc_lo <= prod[31:0];
      acc_hi <= prod[63:32];
    end else if (state == S_KEY && mcnt == 2'd2) begin
      acc_hi <= acc_hi_next;
    end
  end

  // Working state, which also holds the finished keystream block.
  always_ff @(posedge clk) begin
    unique case (state)
      S_INIT:  x <= init_w;
      S_ROUND: x <= x_round;
      S_FEED:  x <= ks;
      S_IDLE, S_KEY: ;
      default: ;
    endcase
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && !restart && !pos[4]) begin
      random_value <= {x[{pos[3:1], 1'b1}], x[{pos[3:1], 1'b0}]};
      new_block    <= 1'b0;
    end else if (state == S_FEED) begin
      random_value <= {ks[1], ks[0]};
      new_block    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed_value <= 64'd0;
      key[0]     <= 32'd0;
      key[1]     <= 32'd0;
      key[2]     <= SEED_XOR[31:0];
      key[3]     <= SEED_XOR[63:32];
      key[4]     <= 32'd0;
      key[5]     <= 32'd0;
      key[6]     <= 32'hFFFFFFFF;
      key[7]     <= 32'hFFFFFFFF;
      ctr        <= 64'd0;
      pos        <= 5'd16;
      out_valid  <= 1'b0;
      half       <= 1'b0;
      col        <= 2'd0;
      diag       <= 1'b0;
      dround     <= '0;
      mcnt       <= 2'd0;
    end else begin
      if (cfg_we) begin
        seed_value <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (restart) begin
              key[0] <= seed_value[31:0];
              key[1] <= seed_value[63:32];
              key[2] <= seed_value[31:0] ^ SEED_XOR[31:0];
              key[3] <= seed_value[63:32] ^ SEED_XOR[63:32];
              key[6] <= ~seed_value[31:0];
              key[7] <= ~seed_value[63:32];
              ctr    <= 64'd0;
              pos    <= 5'd16;
              mcnt   <= 2'd0;
              state  <= S_KEY;
            end else if (pos[4]) begin
              state <= S_INIT;
            end else begin
              out_valid <= 1'b1;
              pos       <= pos + 5'd2;
            end
          end
        end
        S_KEY: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            key[4] <= acc_lo;
            key[5] <= acc_hi_next;
            state  <= S_INIT;
          end
        end
        S_INIT: begin
          half   <= 1'b0;
          col    <= 2'd0;
          diag   <= 1'b0;
          dround <= '0;
          state  <= S_ROUND;
        end
        S_ROUND: begin
          half <= ~half;
          if (half) begin
            col <= col + 2'd1;
            if (col == 2'd3) begin
              diag <= ~diag;
              if (diag) begin
                dround <= dround + DR_W'(1);
              end
            end
          end
          if (last_step) begin
            state <= S_FEED;
          end
        end
        S_FEED: begin
          out_valid <= 1'b1;
          ctr       <= ctr + 64'd1;
          pos       <= 5'd2;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The buffer position only takes even values up to sixteen.
  a_pos_even: assert property (@(posedge clk) disable iff (rst)
    !pos[0] && (!pos[4] || pos[3:0] == 4'd0))
    else $error("buffer position out of range");

  // Finishing a block presents its first draw and marks it as fresh.
  a_feed_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FEED |=> out_valid && new_block && pos == 5'd2)
    else $error("fresh block not presented");

  // A restart clears the counter and empties the buffer before key derivation.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && restart |=> state == S_KEY && ctr == 64'd0 && pos == 5'd16)
    else $error("restart did not reinitialize");

endmodule

### verif/tb.sv
// Self-checking testbench for chacha20_keystream_prng: draws with and without restart,
// checked against an in-bench ChaCha keystream predictor over several seeds and pacings.
// Depends only on the RTL of the generator and its package.
`timescale 1ns / 1ps

module tb;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 275;

  // "expand 32-byte k" and the seed mixing constants.
  localparam logic [31:0] EXPAND_0 = 32'h61707865;
  localparam logic [31:0] EXPAND_1 = 32'h3320646e;
  localparam logic [31:0] EXPAND_2 = 32'h79622d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b206574;
  localparam logic [63:0] SEED_XOR_MASK = 64'h123456789ABCDEF0;
  localparam logic [63:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;

  typedef struct {
    logic [63:0] value;
    logic        fresh;
  } draw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] random_value;
  logic        new_block;

  // Predictor state.
  logic [63:0] shadow_seed;
  logic [31:0] chacha_key [8];
  logic [63:0] block_ctr;
  logic [31:0] keystream [16];
  int          keystream_pos;
  logic [31:0] mix [16];
  logic [31:0] init_words [16];

  logic        pending_restarts [$];
  draw_t       expected_draws [$];

  int idle_in_pct = 0;
  int stall_out_pct = 0;
  int fail_count = 0;
  int draws_checked = 0;
  int fresh_blocks = 0;
  int restarts_sent = 0;
  int seed_settings = 0;
  int cycle_count = 0;

  chacha20_keystream_prng #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .random_value(random_value),
    .new_block(new_block)
  );

  always #5 clk = ~clk;

  function logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void quarter_round(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
  endfunction

  function void reseed_generator();
    logic [63:0] derived [4];
    int i;
    derived[0] = shadow_seed;
    derived[1] = shadow_seed ^ SEED_XOR_MASK;
    derived[2] = shadow_seed * GOLDEN_MUL;
    derived[3] = ~shadow_seed;
    for (i = 0; i < 4; i++) begin
      chacha_key[2 * i] = derived[i][31:0];
      chacha_key[2 * i + 1] = derived[i][63:32];
    end
    block_ctr = '0;
    keystream_pos = 16;
  endfunction

  function void compute_keystream_block();
    int i;
    init_words[0] = EXPAND_0;
    init_words[1] = EXPAND_1;
    init_words[2] = EXPAND_2;
    init_words[3] = EXPAND_3;
    for (i = 0; i < 8; i++) init_words[4 + i] = chacha_key[i];
    init_words[12] = block_ctr[31:0];
    init_words[13] = block_ctr[63:32];
    init_words[14] = '0;
    init_words[15] = '0;
    for (i = 0; i < 16; i++) mix[i] = init_words[i];
    for (i = 0; i < DOUBLE_ROUNDS; i++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(1, 5, 9, 13);
      quarter_round(2, 6, 10, 14);
      quarter_round(3, 7, 11, 15);
      quarter_round(0, 5, 10, 15);
      quarter_round(1, 6, 11, 12);
      quarter_round(2, 7, 8, 13);
      quarter_round(3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) keystream[i] = mix[i] + init_words[i];
    block_ctr = block_ctr + 64'd1;
    keystream_pos = 0;
  endfunction

  function void predict_draw(input logic rs);
    draw_t d;
    int p;
    if (rs) reseed_generator();
    d.fresh = 1'b0;
    if (keystream_pos >= 16) begin
      compute_keystream_block();
      d.fresh = 1'b1;
    end
    p = keystream_pos & 14;
    d.value = {keystream[p + 1], keystream[p]};
    keystream_pos = p + 2;
    expected_draws.push_back(d);
  endfunction

  // Driver: offers queued draw requests and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_draw(restart);
        if (restart) restarts_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_restarts.size() > 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          in_valid <= 1'b1;
          restart <= pending_restarts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    draw_t d;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          $error("unexpected result: random_value %h new_block %b", random_value, new_block);
          fail_count++;
        end else begin
          d = expected_draws.pop_front();
          draws_checked++;
          if (d.fresh) fresh_blocks++;
          if (random_value !== d.value) begin
            $error("random_value: expected %h, got %h", d.value, random_value);
            fail_count++;
          end
          if (new_block !== d.fresh) begin
            $error("new_block: expected %b, got %b", d.fresh, new_block);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_out_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_draws.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_restarts.size() != 0 || in_valid || expected_draws.size() != 0);
  endtask

  // Called only while the generator is idle; the seed takes effect on the next restart.
  task automatic write_seed(input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_seed = value;
    seed_settings++;
  endtask

  task automatic run_random_phase(input logic [63:0] seed, input int in_pct, input int out_pct);
    int i;
    wait_for_drain();
    write_seed(seed);
    idle_in_pct = in_pct;
    stall_out_pct = out_pct;
    // Mostly plain draws so buffers are consumed to the end; restarts land at random positions.
    pending_restarts.push_back(1'b1);
    for (i = 1; i < ITEMS_PER_PHASE; i++) pending_restarts.push_back($urandom_range(0, 15) == 0);
  endtask

  initial begin
    int i;
    shadow_seed = '0;
    reseed_generator();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset seed: run past one full buffer into the second block, then restart mid-buffer.
    for (i = 0; i < 9; i++) pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);

    // A seed write alone must not change the stream; the following restart picks it up.
    wait_for_drain();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);

    // Back-to-back restarts recompute the same first block.
    wait_for_drain();
    write_seed(64'h8000_0000_0000_0001);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b1);
    for (i = 0; i < 3; i++) pending_restarts.push_back(1'b0);

    run_random_phase({$urandom, $urandom}, 0, 0);
    run_random_phase(64'h0, 75, 0);
    run_random_phase(64'hFFFF_FFFF_FFFF_FFFF, 0, 75);
    run_random_phase({$urandom, $urandom}, 11, 11);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_draws.size() != 0) begin
      $error("%0d expected results never arrived", expected_draws.size());
      fail_count++;
    end

    $display("Checked %0d draws with %0d fresh blocks and %0d restarts over %0d seed writes,",
             draws_checked, fresh_blocks, restarts_sent, seed_settings);
    $display("under free-running, idle-sender, stalled-receiver and mixed handshake pacing.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
